### hw/rtl/icmp_echo_check_and_reply_rewrite_top_defines.svh
// Assertion macros for the ICMP echo check and reply rewrite block.
`ifndef ICMP_ECHO_CHECK_AND_REPLY_REWRITE_TOP_DEFINES_SVH
`define ICMP_ECHO_CHECK_AND_REPLY_REWRITE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/icmp_echo_pkg.sv
// Types, constants and helper functions of the ICMP echo check and reply rewrite block.
package icmp_echo_pkg;

    // Stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;

    // ICMP types
    localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REP = 8'd0;
    localparam logic [7:0] ICMP_CODE_0   = 8'd0;

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Beat position codes
    localparam logic [1:0] BI_FIRST  = 2'd0;
    localparam logic [1:0] BI_SECOND = 2'd1;
    localparam logic [1:0] BI_HDR    = 2'd2;
    localparam logic [1:0] BI_BODY   = 2'd3;

    // Keep pair codes per 16-bit lane
    localparam logic [1:0] KP_BOTH = 2'b11;
    localparam logic [1:0] KP_LOW  = 2'b01;

    localparam logic [15:0] OC_ALL_ONES = 16'hFFFF;

    // One result item
    typedef struct packed {
        logic        run_end;
        logic        kind;
        logic [15:0] cs;
        logic        ok;
        logic        last;
        logic [7:0]  keep;
        logic [63:0] data;
    } t_res;

    // Ones'-complement add with a single end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = s + {16'd0, s[16]};
        return f[15:0];
    endfunction

    // Byte-swap one 16-bit word
    function automatic logic [15:0] swap16(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

endpackage

### hw/rtl/icmp_echo_check_and_reply_rewrite_top.sv
// ICMP echo check and reply rewrite: beat rewrite, lane checksums and end-of-packet verdict.
//
// Takes an IPv4/ICMP packet as 64-bit beats (20-byte header, no options) and
// passes each beat out one beat late, with the IP addresses swapped and the
// ICMP type set to echo reply. After the last beat it emits the held last
// beat and then a verdict item: packet_ok is set when the ICMP checksum folds
// to all ones and the packet is an echo request of code 0 at least three
// beats long; reply_checksum is the checksum field adjusted for the type
// change (incremental update), in raw lane byte order. Rate: one input beat
// per clock while the result stream is ready; the last beat of a packet
// yields three result items (two for a one-beat packet), and since the
// output register sends one item per clock the input stalls at each packet
// end while the extra items drain. An accepted beat passes through the input
// register and then the result queue. The input is held in a two-entry
// skid stage, so s_axis_tready is registered.
module icmp_echo_check_and_reply_rewrite_top
    import icmp_echo_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // in_data[63:0], in_keep[71:64]
    input  logic                   s_axis_tlast,   // in_last
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_data[63:0], out_keep[71:64],
                                                   // packet_ok[72], reply_checksum[88:73],
                                                   // zero[95:89]
    output logic                   m_axis_tlast,   // out_last
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // item_kind[0], run_end[1]
);

`include "icmp_echo_check_and_reply_rewrite_top_defines.svh"

    // Input skid stage
    logic        r_p_vld;
    logic [63:0] r_p_data;
    logic [7:0]  r_p_keep;
    logic        r_p_last;
    logic        r_s_vld;
    logic [63:0] r_s_data;
    logic [7:0]  r_s_keep;
    logic        r_s_last;

    // Packet state
    logic [3:0][15:0] r_sums, n_sums;
    logic [1:0]       r_bi, n_bi;
    logic [63:0]      r_held_data, n_held_data;
    logic [7:0]       r_held_keep;
    logic             r_held_last;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_code, n_code;
    logic [15:0]      r_field, n_field;
    logic             r_hdr, n_hdr;

    // Result queue
    t_res       r_q [3];
    logic [1:0] r_cnt;
    t_res       n_b [3];
    logic [1:0] n_b_cnt;

    logic take, pop, load, p_free;

    // Work signals
    t_res        a_res, l_res, v_res;
    logic [15:0] s0, s1, s_all;
    logic        ok;
    logic [16:0] c_dec;
    logic [15:0] c_fix;

    assign s_axis_tready = !r_s_vld;
    assign take   = s_axis_tvalid && s_axis_tready;
    assign pop    = (r_cnt != 2'd0) && m_axis_tready;
    assign load   = r_p_vld && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign p_free = !r_p_vld || load;

    // Hold input items in the skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            if (p_free) begin
                r_p_vld <= r_s_vld || take;
                r_s_vld <= 1'b0;
            end else if (take) begin
                r_s_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_free) begin
            if (r_s_vld) begin
                r_p_data <= r_s_data;
                r_p_keep <= r_s_keep;
                r_p_last <= r_s_last;
            end else if (take) begin
                r_p_data <= s_axis_tdata[63:0];
                r_p_keep <= s_axis_tdata[71:64];
                r_p_last <= s_axis_tlast;
            end
        end else if (take) begin
            r_s_data <= s_axis_tdata[63:0];
            r_s_keep <= s_axis_tdata[71:64];
            r_s_last <= s_axis_tlast;
        end
    end

    // Rewrite the beat and advance the lane sums
    always_comb begin
        n_sums      = r_sums;
        n_hdr       = r_hdr;
        n_type      = r_type;
        n_code      = r_code;
        n_field     = r_field;
        n_held_data = r_p_data;

        a_res       = '0;
        a_res.kind  = KIND_DATA;
        a_res.data  = r_held_data;
        a_res.keep  = r_held_keep;
        a_res.last  = r_held_last;

        case (r_bi)
            BI_FIRST: begin
                n_sums = '0;
                n_hdr  = 1'b0;
            end
            BI_SECOND: begin
            end
            BI_HDR: begin
                a_res.data  = {r_p_data[31:0], r_held_data[31:0]};
                a_res.keep  = 8'hFF;
                a_res.last  = 1'b0;
                n_type      = r_p_data[39:32];
                n_code      = r_p_data[47:40];
                n_field     = r_p_data[63:48];
                n_hdr       = 1'b1;
                for (int i = 2; i < 4; i++) begin
                    n_sums[i] = oc_add(r_sums[i], swap16(r_p_data[16*i +: 16]));
                end
                n_held_data = {r_p_data[63:40], ICMP_ECHO_REP, r_held_data[63:32]};
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_p_keep[2*i +: 2] == KP_BOTH) begin
                        n_sums[i] = oc_add(r_sums[i], swap16(r_p_data[16*i +: 16]));
                    end else if (r_p_keep[2*i +: 2] == KP_LOW) begin
                        n_sums[i] = oc_add(r_sums[i], {r_p_data[16*i +: 8], 8'h00});
                    end
                end
            end
        endcase

        // Verdict and incremental checksum update
        s0    = oc_add(n_sums[0], n_sums[2]);
        s1    = oc_add(n_sums[1], n_sums[3]);
        s_all = oc_add(s0, s1);
        ok    = n_hdr && (s_all == OC_ALL_ONES) &&
                (n_type == ICMP_ECHO_REQ) && (n_code == ICMP_CODE_0);
        c_dec = {1'b0, ~n_field} - {9'd0, ICMP_ECHO_REQ};
        c_fix = c_dec[15:0] - {15'd0, c_dec[16]};

        l_res       = '0;
        l_res.kind  = KIND_DATA;
        l_res.data  = n_held_data;
        l_res.keep  = r_p_keep;
        l_res.last  = r_p_last;

        v_res         = '0;
        v_res.kind    = KIND_VERDICT;
        v_res.ok      = ok;
        v_res.cs      = ok ? ~c_fix : 16'd0;
        v_res.run_end = 1'b1;

        // Pack the results of this beat
        n_b[0] = a_res;
        n_b[1] = l_res;
        n_b[2] = v_res;
        if (r_bi != BI_FIRST) begin
            if (r_p_last) begin
                n_b_cnt = 2'd3;
            end else begin
                n_b[0].run_end = 1'b1;
                n_b_cnt        = 2'd1;
            end
        end else begin
            n_b[0] = l_res;
            n_b[1] = v_res;
            n_b_cnt = r_p_last ? 2'd2 : 2'd0;
        end

        // Beat position
        if (r_p_last) begin
            n_bi = BI_FIRST;
        end else if (r_bi == BI_BODY) begin
            n_bi = BI_BODY;
        end else begin
            n_bi = r_bi + 2'd1;
        end
    end

    // Update packet state on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums      <= '0;
            r_bi        <= BI_FIRST;
            r_held_data <= '0;
            r_held_keep <= '0;
            r_held_last <= 1'b0;
            r_type      <= '0;
            r_code      <= '0;
            r_field     <= '0;
            r_hdr       <= 1'b0;
        end else if (load) begin
            r_sums      <= n_sums;
            r_bi        <= n_bi;
            r_held_data <= n_held_data;
            r_held_keep <= r_p_keep;
            r_held_last <= r_p_last;
            r_type      <= n_type;
            r_code      <= n_code;
            r_field     <= n_field;
            r_hdr       <= n_hdr;
        end
    end

    // Load or drain the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= n_b_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q[0] <= n_b[0];
            r_q[1] <= n_b[1];
            r_q[2] <= n_b[2];
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    // Drive the result stream
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {7'd0, r_q[0].cs, r_q[0].ok, r_q[0].keep, r_q[0].data};
    assign m_axis_tlast  = r_q[0].last;
    assign m_axis_tuser  = {r_q[0].run_end, r_q[0].kind};

    // Checks
    `AST_IMPL(a_skid_order, i_clk, i_rst_n, r_s_vld, r_p_vld,
        "skid entry held without a main entry")
    `AST_NEXT(a_last_restart, i_clk, i_rst_n, load && r_p_last, r_bi == BI_FIRST,
        "beat position not reset after packet end")
    `AST_IMPL(a_verdict_end, i_clk, i_rst_n, m_axis_tvalid && r_q[0].kind, r_q[0].run_end,
        "verdict item without run end")
    `AST_IMPL(a_hdr_early, i_clk, i_rst_n, r_bi == BI_SECOND || r_bi == BI_HDR, !r_hdr,
        "header flag set before the header beat")

endmodule
